### hw/rtl/rfsr_pkg.sv
package rfsr_pkg;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned DEST_W = 2;
    localparam int unsigned CFG_W  = 2;

    // Largest frame the index field can describe
    localparam int unsigned FRAME_CAP = 64;
    localparam int unsigned FRAME_MIN = 4;

    // Header bytes
    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h02;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h81;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] CFG_FRAME_LENGTH   = 2'd0;
    localparam logic [CFG_W-1:0] CFG_ADDRESS_TOP    = 2'd1;
    localparam logic [CFG_W-1:0] CFG_ADDRESS_BOTTOM = 2'd2;
    localparam logic [CFG_W-1:0] CFG_ADDRESS_SAT    = 2'd3;

    // Destination codes
    localparam logic [DEST_W-1:0] DEST_TOP    = 2'd0;
    localparam logic [DEST_W-1:0] DEST_BOTTOM = 2'd1;
    localparam logic [DEST_W-1:0] DEST_SAT    = 2'd2;
    localparam logic [DEST_W-1:0] DEST_NONE   = 2'd3;

    // Register reset values
    localparam logic [LEN_W-1:0]  RST_FRAME_LENGTH   = 7'd64;
    localparam logic [BYTE_W-1:0] RST_ADDRESS_TOP    = 8'd1;
    localparam logic [BYTE_W-1:0] RST_ADDRESS_BOTTOM = 8'd2;
    localparam logic [BYTE_W-1:0] RST_ADDRESS_SAT    = 8'd3;

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

### hw/rtl/rfsr_ram.sv
module rfsr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/radio_frame_sync_router.sv
// Timing: an item that completes a routed frame moves the sequencer to the read state,
// then to the load state, which puts the first byte in the output register once it is free.
// Throughput: one input item per cycle while collecting; a routed frame is read back
// from the frame RAM one byte at a time (read, then load), and input is held off
// until its last byte has been loaded into the output register.
// Reset: synchronous, active low; clears hunt state, fill count, output valid and
// loads the register defaults. The frame RAM is not cleared.
module radio_frame_sync_router #(
    parameter int unsigned MAX_FRAME = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration
    input  logic                          i_cfg_we,
    input  logic [rfsr_pkg::CFG_W-1:0]    i_cfg_index,
    input  logic [rfsr_pkg::BYTE_W-1:0]   i_cfg_data,
    // Input items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rfsr_pkg::BYTE_W-1:0]   i_rx_byte,
    // Output items
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rfsr_pkg::DEST_W-1:0]   o_destination,
    output logic [rfsr_pkg::IDX_W-1:0]    o_byte_index,
    output logic [rfsr_pkg::BYTE_W-1:0]   o_frame_byte,
    output logic                          o_last_byte
);

    import rfsr_pkg::*;

    localparam int unsigned AW = $clog2(MAX_FRAME);
    localparam int unsigned LIM = (MAX_FRAME < FRAME_CAP) ? MAX_FRAME : FRAME_CAP;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LIM);
    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(FRAME_MIN);
    localparam logic [LEN_W-1:0] ADDR_POS = LEN_W'(3);

    // Hunt phases
    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_GOT02 = 2'd1;
    localparam logic [1:0] PH_FILL  = 2'd2;

    // Sequencer states
    localparam logic [1:0] S_IN = 2'd0;
    localparam logic [1:0] S_RD = 2'd1;
    localparam logic [1:0] S_LD = 2'd2;

    // Configuration registers
    logic [LEN_W-1:0]  r_frame_length;
    logic [BYTE_W-1:0] r_address_top;
    logic [BYTE_W-1:0] r_address_bottom;
    logic [BYTE_W-1:0] r_address_sat;

    // Control state
    logic [1:0]        r_state, n_state;
    logic [1:0]        r_phase, n_phase;
    logic [LEN_W-1:0]  r_fill, n_fill;
    logic [BYTE_W-1:0] r_addr_byte, n_addr_byte;
    logic [DEST_W-1:0] r_dest, n_dest;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [IDX_W-1:0]  r_idx, n_idx;

    // Output register
    logic              r_out_valid, n_out_valid;
    logic [DEST_W-1:0] r_o_dest, n_o_dest;
    logic [IDX_W-1:0]  r_o_idx, n_o_idx;
    t_byte             r_o_byte, n_o_byte;
    logic              r_o_last, n_o_last;

    // Datapath helpers
    logic              in_acc;
    logic              out_acc;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  fill_inc;
    logic [BYTE_W-1:0] addr_byte;
    logic [DEST_W-1:0] match_dest;
    logic              ram_we;
    logic              ram_re;
    t_byte             ram_rdata;
    logic              idx_last;
    logic              out_free;

    assign in_acc  = i_in_valid & o_in_ready;
    assign out_acc = r_out_valid & i_out_ready;
    assign out_free = ~r_out_valid | i_out_ready;

    // Clamp the configured length to the usable range
    always_comb begin
        if (r_frame_length < LEN_MIN) begin
            eff_len = LEN_MIN;
        end else if (r_frame_length > LEN_MAX) begin
            eff_len = LEN_MAX;
        end else begin
            eff_len = r_frame_length;
        end
    end

    assign fill_inc  = r_fill + LEN_W'(1);
    // Byte 3 may be the item completing the frame itself
    assign addr_byte = (r_fill == ADDR_POS) ? i_rx_byte : r_addr_byte;

    // Route by address, first match wins
    always_comb begin
        if (addr_byte == r_address_top) begin
            match_dest = DEST_TOP;
        end else if (addr_byte == r_address_bottom) begin
            match_dest = DEST_BOTTOM;
        end else if (addr_byte == r_address_sat) begin
            match_dest = DEST_SAT;
        end else begin
            match_dest = DEST_NONE;
        end
    end

    assign ram_we   = in_acc & (r_phase == PH_FILL);
    assign ram_re   = (r_state == S_RD);
    assign idx_last = (({1'b0, r_idx} + LEN_W'(1)) == r_len);

    // Frame store; header bytes are not stored, they are constants on readout
    rfsr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(r_fill)),
        .i_wdata (i_rx_byte),
        .i_re    (ram_re),
        .i_raddr (AW'(r_idx)),
        .o_rdata (ram_rdata)
    );

    // Hunt, fill and readout sequencing
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_fill      = r_fill;
        n_addr_byte = r_addr_byte;
        n_dest      = r_dest;
        n_len       = r_len;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_o_dest    = r_o_dest;
        n_o_idx     = r_o_idx;
        n_o_byte    = r_o_byte;
        n_o_last    = r_o_last;

        // Drop the output item once taken
        if (out_acc) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IN: begin
                if (in_acc) begin
                    case (r_phase)
                        PH_HUNT: begin
                            if (i_rx_byte == HDR_FIRST) begin
                                n_phase = PH_GOT02;
                            end
                        end
                        PH_GOT02: begin
                            if (i_rx_byte == HDR_SECOND) begin
                                n_phase = PH_FILL;
                                n_fill  = LEN_W'(2);
                            end else if (i_rx_byte != HDR_FIRST) begin
                                n_phase = PH_HUNT;
                            end
                        end
                        PH_FILL: begin
                            n_fill = fill_inc;
                            if (r_fill == ADDR_POS) begin
                                n_addr_byte = i_rx_byte;
                            end
                            if (fill_inc >= eff_len) begin
                                n_phase = PH_HUNT;
                                n_fill  = '0;
                                if (match_dest != DEST_NONE) begin
                                    n_dest  = match_dest;
                                    n_len   = eff_len;
                                    n_idx   = '0;
                                    n_state = S_RD;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_HUNT;
                            n_fill  = '0;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                // Load the output register once it is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_dest    = r_dest;
                    n_o_idx     = r_idx;
                    n_o_last    = idx_last;
                    if (r_idx == IDX_W'(0)) begin
                        n_o_byte = HDR_FIRST;
                    end else if (r_idx == IDX_W'(1)) begin
                        n_o_byte = HDR_SECOND;
                    end else begin
                        n_o_byte = ram_rdata;
                    end
                    if (idx_last) begin
                        n_state = S_IN;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length   <= RST_FRAME_LENGTH;
            r_address_top    <= RST_ADDRESS_TOP;
            r_address_bottom <= RST_ADDRESS_BOTTOM;
            r_address_sat    <= RST_ADDRESS_SAT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_LENGTH:   r_frame_length   <= i_cfg_data[LEN_W-1:0];
                CFG_ADDRESS_TOP:    r_address_top    <= i_cfg_data;
                CFG_ADDRESS_BOTTOM: r_address_bottom <= i_cfg_data;
                CFG_ADDRESS_SAT:    r_address_sat    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IN;
            r_phase     <= PH_HUNT;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr_byte <= n_addr_byte;
        r_dest      <= n_dest;
        r_len       <= n_len;
        r_idx       <= n_idx;
        r_o_dest    <= n_o_dest;
        r_o_idx     <= n_o_idx;
        r_o_byte    <= n_o_byte;
        r_o_last    <= n_o_last;
    end

    assign o_in_ready    = (r_state == S_IN);
    assign o_out_valid   = r_out_valid;
    assign o_destination = r_o_dest;
    assign o_byte_index  = r_o_idx;
    assign o_frame_byte  = r_o_byte;
    assign o_last_byte   = r_o_last;

endmodule

### hw/rtl/rfsr_checker.sv
module rfsr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [rfsr_pkg::DEST_W-1:0]   o_destination,
    input  logic [rfsr_pkg::IDX_W-1:0]    o_byte_index,
    input  logic [rfsr_pkg::BYTE_W-1:0]   o_frame_byte,
    input  logic                          o_last_byte
);

    import rfsr_pkg::*;

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output item valid after reset");

    // A waiting output item holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_destination)
            && $stable(o_byte_index) && $stable(o_frame_byte) && $stable(o_last_byte))
        else $error("output item changed while stalled");

    // Only real stations are routed to
    a_dest_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_destination != DEST_NONE)
        else $error("output item routed to no station");

    // Frames open with the header
    a_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_byte_index != 6'd0 || o_frame_byte == HDR_FIRST)
            && (o_byte_index != 6'd1 || o_frame_byte == HDR_SECOND))
        else $error("frame header byte wrong");

    // Input stays held off while a frame is still being read out
    a_busy_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_byte |-> !o_in_ready)
        else $error("input taken in the middle of a frame burst");

endmodule

bind radio_frame_sync_router rfsr_checker u_rfsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_destination (o_destination),
    .o_byte_index  (o_byte_index),
    .o_frame_byte  (o_frame_byte),
    .o_last_byte   (o_last_byte)
);

### bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rfsr_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 180;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES  = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int UNCHECKED    = -1;
    localparam int N_ROWS       = 38;

    typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, COLLECT} hunt_state_e;
    typedef enum logic {ROW_BYTE, ROW_REG} row_kind_e;

    typedef struct packed {
        logic [DEST_W-1:0] dest;
        logic [IDX_W-1:0]  index;
        t_byte             value;
        logic              last;
    } routed_byte_t;

    // The register index is only meaningful on register rows
    typedef struct {
        row_kind_e         kind;
        t_byte             value;
        logic [CFG_W-1:0]  reg_idx;
        int                typed_count;
        logic [DEST_W-1:0] typed_dest;
    } stim_row_t;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              cfg_we      = 1'b0;
    logic [CFG_W-1:0]  cfg_index   = CFG_FRAME_LENGTH;
    t_byte             cfg_data    = '0;
    logic              in_valid    = 1'b0;
    t_byte             rx_byte     = '0;
    logic              out_ready   = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [DEST_W-1:0] o_destination;
    logic [IDX_W-1:0]  o_byte_index;
    t_byte             o_frame_byte;
    logic              o_last_byte;

    wire in_fire  = in_valid && o_in_ready;
    wire out_fire = o_out_valid && out_ready;

    // Frame sync state as the block should hold it
    hunt_state_e       phase      = HUNT_FIRST;
    logic [LEN_W-1:0]  fill_count = '0;
    t_byte             frame_buf [FRAME_CAP];
    logic [LEN_W-1:0]  cfg_len    = RST_FRAME_LENGTH;
    t_byte             cfg_top    = RST_ADDRESS_TOP;
    t_byte             cfg_bottom = RST_ADDRESS_BOTTOM;
    t_byte             cfg_sat    = RST_ADDRESS_SAT;

    routed_byte_t      pending_routed [$];
    int                last_count;
    logic [DEST_W-1:0] completed_dest;
    int                mismatch_count = 0;
    bit                calm = 1'b0;
    int                stall_left = 0;

    // Directed frames: sliding header, reset addresses, length clamps, a length
    // change mid-frame, equal addresses and an unknown address
    stim_row_t directed_rows [N_ROWS] = '{
        '{ROW_REG,  8'h00, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h02, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h02, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h81, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'hFF, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h01, CFG_FRAME_LENGTH,   4,         DEST_TOP},
        '{ROW_BYTE, 8'h81, CFG_FRAME_LENGTH,   0,         DEST_NONE},
        '{ROW_BYTE, 8'h02, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h81, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h00, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h02, CFG_FRAME_LENGTH,   4,         DEST_BOTTOM},
        '{ROW_REG,  8'hFF, CFG_ADDRESS_SAT,    UNCHECKED, DEST_NONE},
        '{ROW_REG,  8'hFF, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h02, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h81, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h33, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'hFF, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h44, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h55, CFG_FRAME_LENGTH,   0,         DEST_NONE},
        '{ROW_REG,  8'h05, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h66, CFG_FRAME_LENGTH,   5,         DEST_SAT},
        '{ROW_REG,  8'h04, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_REG,  8'h80, CFG_ADDRESS_TOP,    UNCHECKED, DEST_NONE},
        '{ROW_REG,  8'h80, CFG_ADDRESS_BOTTOM, UNCHECKED, DEST_NONE},
        '{ROW_REG,  8'h80, CFG_ADDRESS_SAT,    UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h02, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h81, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h00, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h80, CFG_FRAME_LENGTH,   4,         DEST_TOP},
        '{ROW_REG,  8'h00, CFG_ADDRESS_TOP,    UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h02, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h81, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h00, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h80, CFG_FRAME_LENGTH,   4,         DEST_BOTTOM},
        '{ROW_BYTE, 8'h02, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h81, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h00, CFG_FRAME_LENGTH,   UNCHECKED, DEST_NONE},
        '{ROW_BYTE, 8'h11, CFG_FRAME_LENGTH,   0,         DEST_NONE}
    };

    radio_frame_sync_router uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_destination (o_destination),
        .o_byte_index  (o_byte_index),
        .o_frame_byte  (o_frame_byte),
        .o_last_byte   (o_last_byte)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    // Frame length clamped to what the index field can describe
    function automatic int unsigned effective_len();
        int unsigned len;
        len = cfg_len;
        if (len < FRAME_MIN) len = FRAME_MIN;
        if (len > FRAME_CAP) len = FRAME_CAP;
        return len;
    endfunction

    // Advance the hunt by one received byte; queue the routed bytes it releases
    function automatic int frame_sync_predict(input t_byte b);
        int unsigned       len;
        logic [DEST_W-1:0] dest;
        routed_byte_t      r;
        completed_dest = DEST_NONE;
        case (phase)
            HUNT_FIRST: begin
                if (b == HDR_FIRST) phase = HUNT_SECOND;
            end
            HUNT_SECOND: begin
                if (b == HDR_SECOND) begin
                    frame_buf[0] = HDR_FIRST;
                    frame_buf[1] = HDR_SECOND;
                    fill_count = LEN_W'(2);
                    phase = COLLECT;
                end else if (b != HDR_FIRST) begin
                    phase = HUNT_FIRST;
                end
            end
            default: begin
                if (fill_count < FRAME_CAP) frame_buf[fill_count[IDX_W-1:0]] = b;
                fill_count = fill_count + 1'b1;
                len = effective_len();
                if (fill_count < len) return 0;
                phase = HUNT_FIRST;
                fill_count = '0;
                // First match wins: top, then bottom, then satellite
                if (frame_buf[3] == cfg_top) dest = DEST_TOP;
                else if (frame_buf[3] == cfg_bottom) dest = DEST_BOTTOM;
                else if (frame_buf[3] == cfg_sat) dest = DEST_SAT;
                else return 0;
                completed_dest = dest;
                for (int i = 0; i < len; i++) begin
                    r.dest  = dest;
                    r.index = IDX_W'(i);
                    r.value = frame_buf[r.index];
                    r.last  = (i == len - 1);
                    pending_routed.push_back(r);
                end
                return len;
            end
        endcase
        return 0;
    endfunction

    // Offer one item and wait until the block takes it
    task automatic send_byte(input t_byte b);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        last_count = frame_sync_predict(b);
    endtask

    // Hold input until every routed byte has come out
    task automatic await_routed_drain();
        while (pending_routed.size() != 0) @(posedge i_clk);
    endtask

    // Write a register once the block has gone quiet
    task automatic write_reg(input logic [CFG_W-1:0] idx, input t_byte data);
        in_valid <= 1'b0;
        await_routed_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_LENGTH:   cfg_len    = data[LEN_W-1:0];
            CFG_ADDRESS_TOP:    cfg_top    = data;
            CFG_ADDRESS_BOTTOM: cfg_bottom = data;
            default:            cfg_sat    = data;
        endcase
    endtask

    // Pace the output side: stall for a random number of cycles after each item
    always @(posedge i_clk) begin : sink_pace
        int gap;
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end else if (out_fire) begin
            gap = draw_gap();
            stall_left <= gap;
            out_ready  <= (gap == 0);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Compare each routed byte with the oldest expectation
    always @(posedge i_clk) begin : routed_check
        routed_byte_t want;
        if (i_rst_n && out_fire) begin
            if (pending_routed.size() == 0) begin
                $error("unexpected item: destination %0d byte_index %0d frame_byte %02h",
                       o_destination, o_byte_index, o_frame_byte);
                mismatch_count++;
            end else begin
                want = pending_routed.pop_front();
                if (o_destination !== want.dest) begin
                    $error("destination: expected %0d, got %0d", want.dest, o_destination);
                    mismatch_count++;
                end
                if (o_byte_index !== want.index) begin
                    $error("byte_index: expected %0d, got %0d", want.index, o_byte_index);
                    mismatch_count++;
                end
                if (o_frame_byte !== want.value) begin
                    $error("frame_byte: expected %02h, got %02h", want.value, o_frame_byte);
                    mismatch_count++;
                end
                if (o_last_byte !== want.last) begin
                    $error("last_byte: expected %0b, got %0b", want.last, o_last_byte);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort when nothing moves on either side for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || in_fire || out_fire) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int                frame_items;
        int                pick;
        int unsigned       flen;
        t_byte             b;
        logic [CFG_W-1:0]  reg_idx;
        t_byte             reg_data;

        frame_items = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int r = 0; r < N_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_REG) begin
                write_reg(directed_rows[r].reg_idx, directed_rows[r].value);
            end else begin
                send_byte(directed_rows[r].value);
                if (directed_rows[r].typed_count != UNCHECKED) begin
                    if (last_count != directed_rows[r].typed_count) begin
                        $error("row %0d item count: expected %0d, got %0d",
                               r, directed_rows[r].typed_count, last_count);
                        mismatch_count++;
                    end else if (last_count > 0 &&
                                 completed_dest != directed_rows[r].typed_dest) begin
                        $error("row %0d destination: expected %0d, got %0d",
                               r, directed_rows[r].typed_dest, completed_dest);
                        mismatch_count++;
                    end
                end
            end
        end

        // Random part: mostly well-formed frames, some noise and broken headers
        while (frame_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) calm = ~calm;

            if ($urandom_range(0, 3) == 0) begin
                reg_idx = CFG_W'($urandom_range(CFG_FRAME_LENGTH, CFG_ADDRESS_SAT));
                if (reg_idx == CFG_FRAME_LENGTH) begin
                    case ($urandom_range(0, 7))
                        0:       reg_data = t_byte'($urandom_range(0, FRAME_MIN - 1));
                        1:       reg_data = t_byte'($urandom_range(FRAME_CAP, 127));
                        default: reg_data = t_byte'($urandom_range(FRAME_MIN, 12));
                    endcase
                    reg_data[BYTE_W-1] = 1'($urandom_range(0, 1));
                end else begin
                    case ($urandom_range(0, 3))
                        0:       reg_data = 8'h00;
                        1:       reg_data = 8'hFF;
                        default: reg_data = t_byte'($urandom_range(0, 255));
                    endcase
                end
                write_reg(reg_idx, reg_data);
            end

            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                // Line noise
                repeat ($urandom_range(1, 6)) send_byte(t_byte'($urandom_range(0, 255)));
            end else if (pick == 1) begin
                // Broken header: first byte, then anything but the second
                send_byte(HDR_FIRST);
                do b = t_byte'($urandom_range(0, 255)); while (b == HDR_SECOND);
                send_byte(b);
            end else begin
                // Finish any frame left open by noise before starting a clean one
                while (phase == COLLECT) send_byte(t_byte'($urandom_range(0, 255)));
                flen = effective_len();
                send_byte(HDR_FIRST);
                send_byte(HDR_SECOND);
                for (int k = 2; k < flen; k++) begin
                    if (k == 3 && $urandom_range(0, 4) != 0) begin
                        case ($urandom_range(0, 2))
                            0:       b = cfg_top;
                            1:       b = cfg_bottom;
                            default: b = cfg_sat;
                        endcase
                    end else begin
                        b = t_byte'($urandom_range(0, 255));
                    end
                    // Occasionally change the length while the frame is filling
                    if (k == flen / 2 && $urandom_range(0, 9) == 0)
                        write_reg(CFG_FRAME_LENGTH, t_byte'($urandom_range(FRAME_MIN, 12)));
                    send_byte(b);
                end
                frame_items += flen;
            end
        end

        // Drain and let the block settle
        in_valid <= 1'b0;
        await_routed_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/rfsr_pkg.sv
hw/rtl/rfsr_ram.sv
hw/rtl/radio_frame_sync_router.sv
hw/rtl/rfsr_checker.sv
bench/testbench.sv
